// File: hdl/pbhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbhp_pkg
// Shared widths, result codes and item types of the binary PGM/PPM header
// parser.
// ----------------------------------------------------------------------------
package pbhp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int FIELD_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_file;
    } in_item_t;

endpackage

// File: hdl/pbhp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbhp_in_if
// Byte stream channel: one file byte and its end-of-file mark per request.
// ----------------------------------------------------------------------------
interface pbhp_in_if
    import pbhp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// File: hdl/pbhp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbhp_out_if
// Result channel: pixel bytes, header reports and header errors.
// ----------------------------------------------------------------------------
interface pbhp_out_if
    import pbhp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  pixel_value;
    logic [FIELD_W-1:0] image_width;
    logic [FIELD_W-1:0] image_height;
    logic [FIELD_W-1:0] max_level;
    logic               last_pixel;

    modport source (output valid, output kind, output pixel_value, output image_width,
                    output image_height, output max_level, output last_pixel,
                    input ready);
    modport sink   (input valid, input kind, input pixel_value, input image_width,
                    input image_height, input max_level, input last_pixel,
                    output ready);
endinterface

// File: hdl/pbhp_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbhp_apb_regs
// APB-style register file holding the colour mode register.
// ----------------------------------------------------------------------------
module pbhp_apb_regs
    import pbhp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic               colour_mode
);

    localparam logic [PADDR_W-3:0] REG_COLOUR_MODE = '0;

    logic [PADDR_W-3:0] reg_index;
    logic               colour_mode_reg;

    assign reg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (reg_index == REG_COLOUR_MODE))
        begin
            colour_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_COLOUR_MODE)
        begin
            prdata[0] = colour_mode_reg;
        end
    end

    assign colour_mode = colour_mode_reg;

endmodule

// File: hdl/pbhp_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbhp_input_stage
// Input register: captures one byte request and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module pbhp_input_stage
    import pbhp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    pbhp_in_if.sink  stream,
    output in_item_t item,
    output logic     item_valid,
    input  logic     item_take
);

    logic     valid_reg;
    in_item_t item_reg;

    assign stream.ready = !valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            item_reg.data_byte   <= stream.data_byte;
            item_reg.end_of_file <= stream.end_of_file;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: hdl/pbhp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbhp_parser
// Header parsing state, pixel counter and result register.
// ----------------------------------------------------------------------------
module pbhp_parser
    import pbhp_pkg::*;
#(
    parameter int DIM_BITS    = 16,
    parameter int LEVEL_LIMIT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       colour_mode,
    input  in_item_t   item,
    input  logic       item_valid,
    output logic       item_take,
    pbhp_out_if.source result
);

    localparam int ACC_W  = DIM_BITS + 4;
    localparam int AREA_W = 2 * DIM_BITS;
    localparam int LEFT_W = AREA_W + 2;

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_WIDTH  = 3'd1;
    localparam logic [2:0] PH_HEIGHT = 3'd2;
    localparam logic [2:0] PH_LEVEL  = 3'd3;
    localparam logic [2:0] PH_PIXELS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    logic [2:0]          phase_reg, phase_next;
    logic                magic_seen_reg, magic_seen_next;
    logic                in_comment_reg, in_comment_next;
    logic                in_token_reg, in_token_next;
    logic                digits_done_reg, digits_done_next;
    logic [DIM_BITS-1:0] value_acc_reg, value_acc_next;
    logic [DIM_BITS-1:0] width_reg, width_next;
    logic [DIM_BITS-1:0] height_reg, height_next;
    logic [DIM_BITS-1:0] level_reg, level_next;
    logic [LEFT_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [AREA_W-1:0]   area_reg;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [BYTE_W-1:0]   pixel_reg, pixel_next;
    logic [FIELD_W-1:0]  out_width_reg, out_height_reg, out_level_reg;
    logic                last_reg, last_next;
    logic                emit;

    logic                is_digit;
    logic                is_blank;
    logic [ACC_W-1:0]    acc_prod;
    logic [DIM_BITS-1:0] acc_sat;
    logic [DIM_BITS-1:0] digit_value;
    logic [LEFT_W-1:0]   image_bytes;
    logic                header_done;
    logic                level_bad;

    assign item_take = item_valid && (!out_valid_reg || result.ready);

    // Width times height is registered in the cycle after the height is stored;
    // at least one further byte arrives before the level token can end.
    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(width_reg) * AREA_W'(height_reg);
    end

    always_comb
    begin
        is_digit    = item.data_byte inside {[CHAR_ZERO:CHAR_NINE]};
        is_blank    = item.data_byte inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
        digit_value = DIM_BITS'(item.data_byte - CHAR_ZERO);
        acc_prod    = ACC_W'(value_acc_reg) * ACC_W'(10) + ACC_W'(digit_value);
        if (acc_prod[ACC_W-1:DIM_BITS] != '0)
        begin
            acc_sat = '1;
        end
        else
        begin
            acc_sat = acc_prod[DIM_BITS-1:0];
        end
        if (colour_mode)
        begin
            image_bytes = LEFT_W'(area_reg) + LEFT_W'({area_reg, 1'b0});
        end
        else
        begin
            image_bytes = LEFT_W'(area_reg);
        end
        level_bad = 32'(value_acc_reg) > 32'(LEVEL_LIMIT);
    end

    always_comb
    begin
        phase_next       = phase_reg;
        magic_seen_next  = magic_seen_reg;
        in_comment_next  = in_comment_reg;
        in_token_next    = in_token_reg;
        digits_done_next = digits_done_reg;
        value_acc_next   = value_acc_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        level_next       = level_reg;
        bytes_left_next  = bytes_left_reg;
        emit             = 1'b0;
        header_done      = 1'b0;
        kind_next        = KIND_PIXEL;
        pixel_next       = '0;
        last_next        = 1'b0;

        case (phase_reg)
            PH_MAGIC:
            begin
                if (magic_seen_reg)
                begin
                    phase_next = PH_WIDTH;
                end
                magic_seen_next = 1'b1;
            end
            PH_WIDTH, PH_HEIGHT, PH_LEVEL:
            begin
                if (in_comment_reg)
                begin
                    if (item.data_byte == CHAR_NL)
                    begin
                        in_comment_next = 1'b0;
                    end
                end
                else if (in_token_reg)
                begin
                    if (is_blank)
                    begin
                        in_token_next = 1'b0;
                        if (phase_reg == PH_WIDTH)
                        begin
                            width_next = value_acc_reg;
                            phase_next = PH_HEIGHT;
                        end
                        else if (phase_reg == PH_HEIGHT)
                        begin
                            height_next = value_acc_reg;
                            phase_next  = PH_LEVEL;
                        end
                        else
                        begin
                            level_next  = value_acc_reg;
                            header_done = 1'b1;
                            emit        = 1'b1;
                            if (level_bad)
                            begin
                                kind_next  = KIND_ERROR;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                kind_next       = KIND_HEADER;
                                bytes_left_next = image_bytes;
                                phase_next      = (area_reg != '0) ? PH_PIXELS : PH_DONE;
                            end
                        end
                    end
                    else if (!digits_done_reg && is_digit)
                    begin
                        value_acc_next = acc_sat;
                    end
                    else
                    begin
                        digits_done_next = 1'b1;
                    end
                end
                else if (is_blank)
                begin
                    in_token_next = 1'b0;
                end
                else if (item.data_byte == CHAR_HASH)
                begin
                    in_comment_next = 1'b1;
                end
                else
                begin
                    in_token_next    = 1'b1;
                    digits_done_next = !is_digit;
                    value_acc_next   = is_digit ? digit_value : '0;
                end
            end
            PH_PIXELS:
            begin
                bytes_left_next = bytes_left_reg - LEFT_W'(1);
                emit            = 1'b1;
                kind_next       = KIND_PIXEL;
                pixel_next      = item.data_byte;
                last_next       = (bytes_left_reg == LEFT_W'(1)) || item.end_of_file;
                if (last_next)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // A file that ends before the header separator is a header error.
        if (item.end_of_file && !header_done && (phase_next <= PH_LEVEL))
        begin
            emit       = 1'b1;
            kind_next  = KIND_ERROR;
            pixel_next = '0;
            last_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            kind_reg       <= kind_next;
            pixel_reg      <= pixel_next;
            last_reg       <= last_next;
            out_width_reg  <= FIELD_W'(width_next);
            out_height_reg <= FIELD_W'(height_next);
            out_level_reg  <= FIELD_W'(level_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_MAGIC;
            magic_seen_reg  <= 1'b0;
            in_comment_reg  <= 1'b0;
            in_token_reg    <= 1'b0;
            digits_done_reg <= 1'b0;
            value_acc_reg   <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            level_reg       <= '0;
            bytes_left_reg  <= '0;
        end
        else
        begin
            if (item_take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (item_take)
            begin
                if (item.end_of_file)
                begin
                    phase_reg       <= PH_MAGIC;
                    magic_seen_reg  <= 1'b0;
                    in_comment_reg  <= 1'b0;
                    in_token_reg    <= 1'b0;
                    digits_done_reg <= 1'b0;
                    value_acc_reg   <= '0;
                    width_reg       <= '0;
                    height_reg      <= '0;
                    level_reg       <= '0;
                    bytes_left_reg  <= '0;
                end
                else
                begin
                    phase_reg       <= phase_next;
                    magic_seen_reg  <= magic_seen_next;
                    in_comment_reg  <= in_comment_next;
                    in_token_reg    <= in_token_next;
                    digits_done_reg <= digits_done_next;
                    value_acc_reg   <= value_acc_next;
                    width_reg       <= width_next;
                    height_reg      <= height_next;
                    level_reg       <= level_next;
                    bytes_left_reg  <= bytes_left_next;
                end
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.pixel_value  = pixel_reg;
    assign result.image_width  = out_width_reg;
    assign result.image_height = out_height_reg;
    assign result.max_level    = out_level_reg;
    assign result.last_pixel   = last_reg;

`ifndef SYNTHESIS
    a_pixels_have_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (bytes_left_reg != '0))
        else $error("pixel phase entered with no bytes left");
    a_comment_token_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_comment_reg && in_token_reg))
        else $error("comment and token active together");
    a_last_only_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_PIXEL)) |-> !last_reg)
        else $error("last pixel mark on a header result");
    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.end_of_file) |=> (phase_reg == PH_MAGIC) && !magic_seen_reg)
        else $error("parser did not restart after end of file");
`endif

endmodule

// File: hdl/pnm_binary_header_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnm_binary_header_parser_unit
// Streaming parser for binary PGM (P5) and PPM (P6) files: header fields
// are decoded and the pixel bytes that follow are passed on.
// ----------------------------------------------------------------------------
// The block accepts one file byte per clock cycle and keeps that rate for as
// long as the result side takes its requests; each byte is held in the input
// register and any result it yields in the result register, and the whole
// parse step for a byte (token digit accumulation, whitespace and comment
// skipping, header checks and the pixel countdown) is combinational between
// them. The two magic bytes are skipped unchecked, then
// width, height and maximum level are read as decimal values saturated at
// 2^DIM_BITS-1 and reported as 16-bit fields. The whitespace byte after the
// level produces one header-complete request, or a header-error request when
// the level exceeds LEVEL_LIMIT; after a header error the rest of the file is
// dropped. The colour_mode register (address 0, bit 0) chooses one or three
// bytes per pixel and is read as the header completes, so it should be
// written between files. The product of width and height is registered in
// the cycle after the height is stored, ready before the level token can end.
// A byte marked end_of_file always returns the parser to its start state;
// if it arrives during the header, a header error is reported, and during
// the pixels it carries the last-pixel mark. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module pnm_binary_header_parser_unit
    import pbhp_pkg::*;
#(
    parameter int DIM_BITS    = 16,
    parameter int LEVEL_LIMIT = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    pbhp_in_if.sink            stream,
    pbhp_out_if.source         result
);

    logic     colour_mode;
    in_item_t item;
    logic     item_valid;
    logic     item_take;

    // Configuration registers.
    pbhp_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .colour_mode (colour_mode)
    );

    // The input register lets a new byte in whenever the parser takes the
    // one it holds, so a stalled result side stalls the stream by one stage.
    pbhp_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // The parser advances its state and, for a byte that yields a result, loads
    // the result register in the same cycle as it takes that byte.
    pbhp_parser #(
        .DIM_BITS    (DIM_BITS),
        .LEVEL_LIMIT (LEVEL_LIMIT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .colour_mode (colour_mode),
        .item        (item),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .result      (result)
    );

endmodule
